/* hdl/gmc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the stage record for the grid minimum climb path cost block.
// No dependencies; every other file imports this package.
package gmc_pkg;

   localparam int MAX_GRID = 128;
   localparam int ADDR_W   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
   localparam int SIZE_W   = $clog2(MAX_GRID + 1);
   localparam int HEIGHT_W = 32;
   localparam int COST_W   = 48;
   localparam int CSR_W    = 8;

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic signed [COST_W-1:0]   cost_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [SIZE_W-1:0]          size_type;

   // Cell in the compute stage
   typedef struct packed {
      logic       valid;
      logic       row0;     // top row: no cell above
      logic       col0;     // left column: no cell to the left
      logic       last;     // bottom-right cell
      addr_type   col;
      height_type height;
   } stage_type;

endpackage

/* hdl/grid_min_climb_path_cost.sv */
`timescale 1ns / 1ps
// Top level: grid position tracking, two-stage cell pipeline, result register.
// Depends on gmc_pkg, gmc_line_buf, gmc_cell_dp.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-----------------------------------
//   req      | in  | req_tvalid / req_tready | req_tdata[31:0]  height (signed)
//   rsp      | out | rsp_tvalid / rsp_tready | rsp_tdata[47:0]  min_cost (signed)
//   csr      | in  | csr_we                  | csr_wdata[7:0]   grid_size
//
// One cell per cycle sustained while req_tready is high. A cell is accepted
// in stage 0, where the line buffer read for its column is issued; stage 1
// computes the cost from the read data and the left-neighbor register and
// writes back the column entry. One result per grid; rsp_tvalid rises once
// the bottom-right cell leaves stage 1 for the result register.
// Synchronous active-high reset clears control state and sets grid_size to 1;
// line buffers are not cleared (each entry is written before its value is used).
// req_tready drops only while a bottom-right cell waits for the result
// register to empty, i.e. an earlier result still stalled on rsp_tready.
module grid_min_climb_path_cost import gmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request: [31:0] height
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: [47:0] min_cost
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // grid_size register
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int CMP_W = (CSR_W > SIZE_W) ? CSR_W : SIZE_W;

   size_type   size_ff, size_in;
   addr_type   col_ff, col_in;
   addr_type   row_ff, row_in;
   stage_type  s1_ff, s1_in;
   logic       rsp_valid_ff, rsp_valid_in;
   cost_type   rsp_cost_ff, rsp_cost_in;

   logic       accept;
   logic       stall;
   logic       advance;
   logic       last_col;
   logic       last_row;
   size_type   col_next;
   size_type   row_next;
   size_type   size_eff;
   height_type up_height;
   cost_type   up_cost;
   cost_type   cell_cost;

   // Saturate grid_size: zero reads as one, anything above the buffer depth as the depth.
   always_comb begin
      if (csr_wdata == '0) begin
         size_eff = SIZE_W'(1);
      end else if (CMP_W'(csr_wdata) > CMP_W'(MAX_GRID)) begin
         size_eff = SIZE_W'(MAX_GRID);
      end else begin
         size_eff = SIZE_W'(csr_wdata);
      end
   end

   // A bottom-right cell cannot leave stage 1 while the result register is full and rsp_tready is low.
   assign stall      = s1_ff.valid && s1_ff.last && rsp_valid_ff && !rsp_tready;
   assign advance    = s1_ff.valid && !stall;
   assign req_tready = !stall;
   assign accept     = req_tvalid && req_tready;

   assign col_next = SIZE_W'(col_ff) + SIZE_W'(1);
   assign row_next = SIZE_W'(row_ff) + SIZE_W'(1);
   assign last_col = (col_next >= size_ff);
   assign last_row = (row_next >= size_ff);

   // Grid position of the next cell; a register write restarts the grid.
   always_comb begin
      size_in = size_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_we) begin
         size_in = size_eff;
         col_in  = '0;
         row_in  = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ADDR_W-1:0];
         end else begin
            col_in = col_next[ADDR_W-1:0];
         end
      end
   end

   // Stage 1 register
   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in.valid  = 1'b1;
         s1_in.row0   = (row_ff == '0);
         s1_in.col0   = (col_ff == '0);
         s1_in.last   = last_col && last_row;
         s1_in.col    = col_ff;
         s1_in.height = height_type'(req_tdata);
      end else if (advance) begin
         s1_in.valid = 1'b0;
      end
   end

   // Result register, doubles as the skid stage toward rsp
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cost_in  = rsp_cost_ff;
      if (advance && s1_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_cost_in  = cell_cost;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff <= rsp_cost_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cost_ff;

   // Column entry read at accept; in a grid of two or more columns the
   // entry was written a full row earlier, so no forwarding is needed.
   gmc_line_buf u_line_buf (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (col_ff),
      .rd_height (up_height),
      .rd_cost   (up_cost),
      .wr_en     (advance),
      .wr_addr   (s1_ff.col),
      .wr_height (s1_ff.height),
      .wr_cost   (cell_cost)
   );

   gmc_cell_dp u_cell_dp (
      .clock     (clock),
      .reset     (reset),
      .stage     (s1_ff),
      .advance   (advance),
      .up_height (up_height),
      .up_cost   (up_cost),
      .cost      (cell_cost)
   );

   // A new result only follows a bottom-right cell in stage 1.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_ff.valid && s1_ff.last))
      else $error("result raised without a bottom-right cell");

   // A stalled bottom-right cell keeps its stage contents.
   assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(s1_ff))
      else $error("stage 1 changed while stalled");

   // Input back-pressure only when stage 1 holds a cell.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_ff.valid)
      else $error("req_tready low with empty stage 1");

   // Position stays inside the grid.
   assert property (@(posedge clock) disable iff (reset)
      (SIZE_W'(col_ff) < size_ff) && (SIZE_W'(row_ff) < size_ff))
      else $error("grid position out of range");

endmodule

/* hdl/gmc_line_buf.sv */
`timescale 1ns / 1ps
// Line buffers: previous row's heights and best costs, one write and one registered read port.
// Depends on gmc_pkg.
module gmc_line_buf import gmc_pkg::*; (
   input  logic       clock,
   input  logic       rd_en,
   input  addr_type   rd_addr,
   output height_type rd_height,
   output cost_type   rd_cost,
   input  logic       wr_en,
   input  addr_type   wr_addr,
   input  height_type wr_height,
   input  cost_type   wr_cost
);

   height_type heights_mem [MAX_GRID];
   cost_type   costs_mem   [MAX_GRID];
   height_type rd_height_ff;
   cost_type   rd_cost_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heights_mem[wr_addr] <= wr_height;
         costs_mem[wr_addr]   <= wr_cost;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_height_ff <= heights_mem[rd_addr];
         rd_cost_ff   <= costs_mem[rd_addr];
      end
   end

   assign rd_height = rd_height_ff;
   assign rd_cost   = rd_cost_ff;

endmodule

/* hdl/gmc_cell_dp.sv */
`timescale 1ns / 1ps
// Per-cell cost datapath: cheaper of the step from above and from the left; holds the left neighbor.
// Top-left cell costs its height; top row and left column take their one step. Depends on gmc_pkg.
module gmc_cell_dp import gmc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   input  logic       advance,
   input  height_type up_height,
   input  cost_type   up_cost,
   output cost_type   cost
);

   height_type left_height_ff, left_height_in;
   cost_type   left_cost_ff, left_cost_in;
   cost_type   up_total;
   cost_type   left_total;
   cost_type   cost_sel;

   // rise from a to b, zero when going downhill
   function automatic cost_type rise(input height_type a, input height_type b);
      cost_type d;
      d = COST_W'(b) - COST_W'(a);
      return (d > 0) ? d : '0;
   endfunction

   always_comb begin
      up_total   = up_cost + rise(up_height, stage.height);
      left_total = left_cost_ff + rise(left_height_ff, stage.height);
      if (stage.row0 && stage.col0) begin
         cost_sel = COST_W'(stage.height);
      end else if (stage.row0) begin
         cost_sel = left_total;
      end else if (stage.col0) begin
         cost_sel = up_total;
      end else begin
         cost_sel = (up_total < left_total) ? up_total : left_total;
      end
   end

   assign cost = cost_sel;

   always_comb begin
      left_height_in = left_height_ff;
      left_cost_in   = left_cost_ff;
      if (advance) begin
         left_height_in = stage.height;
         left_cost_in   = cost_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_height_ff <= '0;
         left_cost_ff   <= '0;
      end else begin
         left_height_ff <= left_height_in;
         left_cost_ff   <= left_cost_in;
      end
   end

endmodule
